[rtl/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int SLOT_COUNT_DEFAULT = 1024;

  localparam logic [31:0] ALIVE_BIT    = 32'h1;
  localparam logic [31:0] DYING_BIT    = 32'h2;
  localparam logic [31:0] INTERNAL_BITS = 32'h3;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_ADD     = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_QUERY   = 3'd4,
    REQ_SWEEP   = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_EXEC,
    ST_SW_RDP,
    ST_SW_RDS,
    ST_SW_WR,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic init_step;
    logic rd_slot;
    logic exec;
    logic sw_start;
    logic sw_rd_pend;
    logic sw_rd_slot;
    logic sw_write;
    logic sw_finish;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic sw_done;
    logic is_sweep;
  } stat_t;

endpackage

[rtl/gha_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps

module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/gha_ctrl.sv]
// Controller state machine for the handle allocator.
`timescale 1ns / 1ps

module gha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             out_busy,
  input  gha_pkg::stat_t   stat,
  output gha_pkg::cmd_t    cmd,
  output logic             in_ready
);

  gha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= gha_pkg::ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      gha_pkg::ST_INIT:   if (stat.init_done) state_next = gha_pkg::ST_IDLE;
      gha_pkg::ST_IDLE:   if (in_fire) state_next = gha_pkg::ST_READ;
      gha_pkg::ST_READ:   state_next = stat.is_sweep ? gha_pkg::ST_SW_RDP : gha_pkg::ST_EXEC;
      gha_pkg::ST_EXEC:   state_next = gha_pkg::ST_OUT;
      gha_pkg::ST_SW_RDP: state_next = stat.sw_done ? gha_pkg::ST_OUT : gha_pkg::ST_SW_RDS;
      gha_pkg::ST_SW_RDS: state_next = gha_pkg::ST_SW_WR;
      gha_pkg::ST_SW_WR:  state_next = gha_pkg::ST_SW_RDP;
      gha_pkg::ST_OUT:    if (!out_busy) state_next = gha_pkg::ST_IDLE;
      default:            state_next = gha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      gha_pkg::ST_INIT:   cmd.init_step = 1'b1;
      gha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_req = 1'b1;
      end
      gha_pkg::ST_READ: begin
        cmd.rd_slot  = 1'b1;
        cmd.sw_start = 1'b1;
      end
      gha_pkg::ST_EXEC:   cmd.exec = 1'b1;
      gha_pkg::ST_SW_RDP: begin
        cmd.sw_rd_pend = 1'b1;
        cmd.sw_finish  = stat.sw_done;
      end
      gha_pkg::ST_SW_RDS: cmd.sw_rd_slot = 1'b1;
      gha_pkg::ST_SW_WR:  cmd.sw_write = 1'b1;
      gha_pkg::ST_OUT:    cmd.out_load = !out_busy;
      default:            cmd = '0;
    endcase
  end

endmodule

[rtl/gha_datapath.sv]
// Slot tables, free stack, pending list and result formation.
`timescale 1ns / 1ps

module gha_datapath #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  gha_pkg::cmd_t   cmd,
  output gha_pkg::stat_t  stat,
  input  logic [66:0]     in_data,
  output logic [51:0]     res
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOT_COUNT);

  logic [2:0]  req;
  logic [15:0] r_idx, r_gen;
  logic [31:0] r_bits;

  logic [CW-1:0] free_top, live, pend_total, sw_i, init_cnt;
  logic [AW-1:0] sw_slot, cr_slot;

  // memory ports
  logic          m_we, g_we, f_we, p_we;
  logic [AW-1:0] m_wa, m_ra, g_wa, g_ra, f_wa, f_ra, p_wa, p_ra;
  logic [31:0]   m_wd, m_rd;
  logic [15:0]   g_wd, g_rd;
  logic [AW-1:0] f_wd, f_rd, p_wd, p_rd;

  gha_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_mask (.clk, .we(m_we), .waddr(m_wa),
    .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  gha_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_gen (.clk, .we(g_we), .waddr(g_wa),
    .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  gha_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_free (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  gha_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_pend (.clk, .we(p_we), .waddr(p_wa),
    .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic in_range, valid, create_ok, destroy_ok;
  logic [AW-1:0] hidx;

  assign in_range = (32'(r_idx) < 32'(SLOT_COUNT));
  assign hidx     = AW'(r_idx);
  assign valid    = in_range && (m_rd != '0) && (g_rd == r_gen);
  // in EXEC for create, f_rd holds the popped slot
  assign cr_slot  = f_rd;
  assign create_ok  = (req == gha_pkg::REQ_CREATE) && (free_top != '0);
  assign destroy_ok = (req == gha_pkg::REQ_DESTROY) && valid && m_rd[0];

  assign stat.init_done = (init_cnt == FULL - CW'(1));
  assign stat.sw_done   = (sw_i == pend_total);
  assign stat.is_sweep  = (req == gha_pkg::REQ_SWEEP);

  logic [CW-1:0] ftop_m1;
  assign ftop_m1 = free_top - CW'(1);

  always_comb begin
    m_we = 1'b0; m_wa = hidx; m_wd = '0; m_ra = hidx;
    g_we = 1'b0; g_wa = sw_slot; g_wd = g_rd + 16'd1; g_ra = hidx;
    f_we = 1'b0; f_wa = AW'(free_top); f_wd = sw_slot; f_ra = AW'(ftop_m1);
    p_we = 1'b0; p_wa = AW'(pend_total); p_wd = hidx; p_ra = AW'(sw_i);
    if (cmd.init_step) begin
      f_we = 1'b1; f_wa = AW'(init_cnt);
      f_wd = AW'(FULL - CW'(1) - init_cnt);
      m_we = 1'b1; m_wa = AW'(init_cnt);
      g_we = 1'b1; g_wa = AW'(init_cnt); g_wd = '0;
    end
    if (cmd.rd_slot && req == gha_pkg::REQ_CREATE) begin
      m_ra = f_rd; g_ra = f_rd;
    end
    if (cmd.exec) begin
      case (req)
        gha_pkg::REQ_CREATE: begin
          m_we = create_ok; m_wa = cr_slot; m_wd = gha_pkg::ALIVE_BIT;
        end
        gha_pkg::REQ_DESTROY: begin
          m_we = destroy_ok; m_wd = (m_rd & ~gha_pkg::ALIVE_BIT) | gha_pkg::DYING_BIT;
          p_we = destroy_ok && (pend_total < FULL);
        end
        gha_pkg::REQ_ADD: begin
          m_we = valid; m_wd = m_rd | (r_bits & ~gha_pkg::INTERNAL_BITS);
        end
        gha_pkg::REQ_REMOVE: begin
          m_we = valid; m_wd = m_rd & ~(r_bits & ~gha_pkg::INTERNAL_BITS);
        end
        default: m_we = 1'b0;
      endcase
    end
    // p_rd carries the queued slot here; sw_slot only takes it at this edge
    if (cmd.sw_rd_slot) g_ra = p_rd;
    if (cmd.sw_write) begin
      m_we = 1'b1; m_wa = sw_slot; m_wd = '0;
      g_we = 1'b1;
      f_we = (free_top < FULL);
    end
  end

  // EXEC for create reads mask/gen of popped slot: issue that read in READ
  // by presenting f_rd, which was read at free_top-1 during IDLE.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= FULL; live <= '0; pend_total <= '0; init_cnt <= '0;
      sw_i <= '0;
    end else begin
      if (cmd.init_step) init_cnt <= init_cnt + CW'(1);
      if (cmd.sw_start) sw_i <= '0;
      if (cmd.exec) begin
        if (create_ok) begin
          free_top <= ftop_m1; live <= live + CW'(1);
        end
        if (destroy_ok) begin
          if (live != '0) live <= live - CW'(1);
          if (pend_total < FULL) pend_total <= pend_total + CW'(1);
        end
      end
      if (cmd.sw_rd_pend && !cmd.sw_finish) sw_i <= sw_i + CW'(1);
      if (cmd.sw_write && free_top < FULL) free_top <= free_top + CW'(1);
      if (cmd.out_load && req == gha_pkg::REQ_SWEEP) pend_total <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data[2:0]; r_idx <= in_data[18:3];
      r_gen <= in_data[34:19]; r_bits <= in_data[66:35];
    end
    if (cmd.sw_rd_slot) sw_slot <= p_rd;
  end

  logic ok, vq, aq, hq;
  logic [9:0]  oi;
  logic [15:0] og;
  logic [10:0] fc, lt;
  always_comb begin
    ok = 1'b0; oi = '0; og = '0; vq = 1'b0; aq = 1'b0; hq = 1'b0; fc = '0;
    case (req)
      gha_pkg::REQ_CREATE: begin
        ok = create_ok;
        oi = create_ok ? 10'(cr_slot) : '0;
        og = create_ok ? g_rd : '0;
      end
      gha_pkg::REQ_DESTROY: ok = destroy_ok;
      gha_pkg::REQ_ADD, gha_pkg::REQ_REMOVE: ok = valid;
      gha_pkg::REQ_QUERY: begin
        vq = valid; aq = valid && m_rd[0]; hq = valid && ((m_rd & r_bits) == r_bits);
      end
      gha_pkg::REQ_SWEEP: begin
        ok = 1'b1; fc = 11'(pend_total);
      end
      default: ok = 1'b0;
    endcase
    lt = 11'(live);
  end

  // hold exec-time result; sweep result formed at OUT
  logic [51:0] held;
  always_ff @(posedge clk) begin
    if (cmd.exec) held <= {11'(live + CW'(create_ok) - CW'(destroy_ok && live != '0)),
                           fc, hq, aq, vq, og, oi, ok};
  end
  assign res = (req == gha_pkg::REQ_SWEEP) ? {lt, fc, 3'b000, 26'd0, 1'b1} : held;

endmodule

[rtl/generational_handle_allocator_core.sv]
// Top level of the generational handle allocator.
`timescale 1ns / 1ps

// A request passes through read, execute and output steps once it is accepted, a
// sweep running its per-slot steps in place of execute, and a new request is taken
// only after the previous one has left its output step. Per queued slot a sweep reads
// the pending list, reads the generation memory, then writes the generation and mask
// memories. One output register holds a result while the next request is accepted;
// a second request then waits in its output step. After reset the block runs a
// clearing pass over all SLOT_COUNT slots before it accepts a request.
module generational_handle_allocator_core #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // req_type, slot_index, slot_generation, component_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok, out_index, out_generation, is_valid, is_alive, has_all, freed_count, live_total
  output logic [55:0] m_tdata
);

  gha_pkg::cmd_t  cmd;
  gha_pkg::stat_t stat;
  logic [51:0] res;

  gha_ctrl u_ctrl (.clk, .rst, .in_fire(s_tvalid && s_tready), .out_busy(m_tvalid && !m_tready),
    .stat, .cmd, .in_ready(s_tready));

  gha_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (.clk, .rst, .cmd, .stat,
    .in_data(s_tdata[66:0]), .res);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {4'd0, res};
  end

endmodule

[rtl/gha_checker.sv]
// Port-level assertions for the handle allocator, bound to the top level.
`timescale 1ns / 1ps

module gha_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready)) else $error("result without a request in flight");
  a_query: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[28] || m_tdata[29]) |-> m_tdata[27]) else $error("alive without valid");

endmodule

bind generational_handle_allocator_core gha_checker u_chk (.clk, .rst, .s_tvalid, .s_tready,
  .m_tvalid, .m_tready, .m_tdata);

[tb/sv/generational_handle_allocator_core_checker.sv]
// Checker for the handle allocator: predicts each response and compares it.
`timescale 1ns / 1ps

module generational_handle_allocator_core_checker #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          pending_responses,
  output int          sweeps_seen,
  output int          creates_failed
);

  logic [31:0] mask_tbl [SLOTS];
  logic [15:0] gen_tbl [SLOTS];
  logic [9:0]  free_lifo [SLOTS];
  int          free_depth;
  int          live_cnt;
  logic [9:0]  doomed_q [$];
  logic [55:0] resp_q [$];

  function automatic logic [55:0] apply_request(input logic [71:0] beat);
    gha_pkg::req_t op;
    logic [15:0] idx;
    logic [15:0] gen;
    logic [31:0] bits;
    logic        ok, vld, alv, hall, hit;
    logic [9:0]  oidx, s;
    logic [15:0] ogen;
    logic [10:0] freed;
    op = gha_pkg::req_t'(beat[2:0]);
    idx = beat[18:3];
    gen = beat[34:19];
    bits = beat[66:35];
    ok = 1'b0; vld = 1'b0; alv = 1'b0; hall = 1'b0; oidx = '0; ogen = '0; freed = '0;
    hit = idx < SLOTS && mask_tbl[idx] != 0 && gen_tbl[idx] == gen;
    case (op)
      gha_pkg::REQ_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          s = free_lifo[free_depth];
          mask_tbl[s] = gha_pkg::ALIVE_BIT;
          live_cnt++;
          ok = 1'b1;
          oidx = s;
          ogen = gen_tbl[s];
        end else begin
          creates_failed++;
        end
      end
      gha_pkg::REQ_DESTROY: begin
        if (hit && (mask_tbl[idx] & gha_pkg::ALIVE_BIT) != 0) begin
          mask_tbl[idx] = (mask_tbl[idx] & ~gha_pkg::ALIVE_BIT) | gha_pkg::DYING_BIT;
          if (live_cnt > 0) live_cnt--;
          doomed_q.push_back(idx[9:0]);
          ok = 1'b1;
        end
      end
      gha_pkg::REQ_ADD: begin
        if (hit) begin
          mask_tbl[idx] |= bits & ~gha_pkg::INTERNAL_BITS;
          ok = 1'b1;
        end
      end
      gha_pkg::REQ_REMOVE: begin
        if (hit) begin
          mask_tbl[idx] &= ~(bits & ~gha_pkg::INTERNAL_BITS);
          ok = 1'b1;
        end
      end
      gha_pkg::REQ_QUERY: begin
        if (hit) begin
          vld = 1'b1;
          alv = mask_tbl[idx][0];
          hall = (mask_tbl[idx] & bits) == bits;
        end
      end
      gha_pkg::REQ_SWEEP: begin
        freed = 11'(doomed_q.size());
        foreach (doomed_q[k]) begin
          s = doomed_q[k];
          mask_tbl[s] = '0;
          gen_tbl[s] = gen_tbl[s] + 16'd1;
          if (free_depth < SLOTS) begin
            free_lifo[free_depth] = s;
            free_depth++;
          end
        end
        doomed_q.delete();
        sweeps_seen++;
        ok = 1'b1;
      end
      default: ;
    endcase
    return {4'd0, live_cnt[10:0], freed, hall, alv, vld, ogen, oidx, ok};
  endfunction

  always @(posedge clk) begin
    logic [55:0] want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        mask_tbl[i] = '0;
        gen_tbl[i] = '0;
        free_lifo[i] = 10'(SLOTS - 1 - i);
      end
      free_depth = SLOTS;
      live_cnt = 0;
      doomed_q.delete();
      resp_q.delete();
      fail_count = 0;
      sweeps_seen = 0;
      creates_failed = 0;
    end else begin
      if (s_tvalid && s_tready) resp_q.push_back(apply_request(s_tdata));
      if (m_tvalid && m_tready) begin
        if (resp_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response %h", $time, m_tdata);
        end else begin
          want = resp_q.pop_front();
          if (want !== m_tdata) begin
            fail_count++;
            $display("%0t: mismatch expected %h actual %h", $time, want, m_tdata);
            $display("  ok %0d/%0d idx %0d/%0d gen %0d/%0d v%0d/%0d a%0d/%0d h%0d/%0d",
                     want[0], m_tdata[0], want[10:1], m_tdata[10:1],
                     want[26:11], m_tdata[26:11], want[27], m_tdata[27],
                     want[28], m_tdata[28], want[29], m_tdata[29]);
            $display("  freed %0d/%0d live %0d/%0d", want[40:30], m_tdata[40:30],
                     want[51:41], m_tdata[51:41]);
          end
        end
      end
    end
    pending_responses = resp_q.size();
  end

endmodule

[tb/sv/generational_handle_allocator_core_tb.sv]
// Testbench top: drives requests into the handle allocator and reports the verdict.
`timescale 1ns / 1ps

module generational_handle_allocator_core_tb;

  localparam int SLOTS = 1024;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  int          fail_count, pending_responses, sweeps_seen, creates_failed;
  bit          hold_off = 0;
  int          sent = 0;

  // handles the stimulus believes were handed out
  logic [15:0] known_idx [$];
  logic [15:0] known_gen [$];

  always #1 clk = ~clk;

  generational_handle_allocator_core #(.SLOT_COUNT(SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  generational_handle_allocator_core_checker #(.SLOTS(SLOTS)) i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_responses(pending_responses),
    .sweeps_seen(sweeps_seen), .creates_failed(creates_failed)
  );

  // learn handles from successful creates
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready && m_tdata[0] && m_tdata[26:1] != 0 &&
        m_tdata[40:27] == 0) begin
      known_idx.push_back({6'd0, m_tdata[10:1]});
      known_gen.push_back(m_tdata[26:11]);
      if (known_idx.size() > 64) begin
        void'(known_idx.pop_front());
        void'(known_gen.pop_front());
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send(input gha_pkg::req_t op, input logic [15:0] idx,
                      input logic [15:0] gen, input logic [31:0] bits);
    s_tdata <= {5'd0, bits, gen, idx, op};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_raw(input logic [2:0] op, input logic [15:0] idx,
                          input logic [15:0] gen, input logic [31:0] bits);
    send(gha_pkg::req_t'(op), idx, gen, bits);
  endtask

  task automatic pause();
    int n;
    n = gap_len();
    if (n > 0) begin
      s_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic random_request(input int mode);
    int          r, k;
    logic [15:0] idx, gen;
    logic [31:0] bits;
    r = $urandom_range(0, 99);
    bits = $urandom();
    if (known_idx.size() > 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, known_idx.size() - 1);
      idx = known_idx[k];
      gen = known_gen[k];
      if ($urandom_range(0, 9) == 0) gen = gen + 16'($urandom_range(1, 2));
    end else begin
      idx = $urandom_range(0, 1) ? 16'($urandom_range(0, SLOTS - 1)) : 16'($urandom());
      gen = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom());
    end
    if ($urandom_range(0, 3) == 0) bits = bits & 32'h0000_00ff;
    if (mode == 1 && r < 40) send(gha_pkg::REQ_CREATE, idx, gen, bits);
    else if (r < 22) send(gha_pkg::REQ_CREATE, idx, gen, bits);
    else if (r < 40) send(gha_pkg::REQ_DESTROY, idx, gen, bits);
    else if (r < 55) send(gha_pkg::REQ_ADD, idx, gen, bits);
    else if (r < 67) send(gha_pkg::REQ_REMOVE, idx, gen, bits);
    else if (r < 90) send(gha_pkg::REQ_QUERY, idx, gen, bits);
    else if (r < 96) send(gha_pkg::REQ_SWEEP, idx, gen, bits);
    else send_raw(3'($urandom_range(6, 7)), idx, gen, bits);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      n = gap_len();
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        m_tready <= 0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL generational_handle_allocator_core");
    $finish;
  end

  initial begin
    int i;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed part
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_CREATE, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_CREATE, 16'hffff, 16'hffff, 32'hffff_ffff);
    send(gha_pkg::REQ_ADD, 16'd0, 16'd0, 32'hffff_ffff);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'hffff_ffff);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'hffff_fffc);
    send(gha_pkg::REQ_REMOVE, 16'd0, 16'd0, 32'hffff_ffff);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_ADD, 16'hffff, 16'd0, 32'hffff_ffff);
    send(gha_pkg::REQ_QUERY, 16'd1, 16'hffff, 32'd0);
    send(gha_pkg::REQ_DESTROY, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_DESTROY, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_ADD, 16'd0, 16'd0, 32'h0000_0f0c);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'h0000_0f0e);
    send(gha_pkg::REQ_REMOVE, 16'd0, 16'd0, 32'h0000_0f0f);
    send_raw(3'd6, 16'd0, 16'd0, 32'd0);
    send_raw(3'd7, 16'hffff, 16'hffff, 32'hffff_ffff);
    send(gha_pkg::REQ_SWEEP, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_SWEEP, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_CREATE, 16'd0, 16'd0, 32'd0);
    send(gha_pkg::REQ_QUERY, 16'd0, 16'd1, 32'd0);
    // drain the stack completely, then fail two creates
    for (i = 0; i < SLOTS; i++) send(gha_pkg::REQ_CREATE, 16'd0, 16'd0, 32'd0);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    for (i = 0; i < 40; i++) random_request(0);
    // destroy a run of slots and sweep them back
    for (i = 0; i < 80; i++) begin
      send(gha_pkg::REQ_DESTROY, 16'(i), 16'(i < 2 ? 1 : 0), 32'd0);
      pause();
    end
    send(gha_pkg::REQ_SWEEP, 16'd0, 16'd0, 32'd0);
    // random part
    for (i = 0; i < 85; i++) begin
      random_request(known_idx.size() < 8);
      pause();
    end
    s_tvalid <= 0;
    while (pending_responses != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Run sent %0d requests, %0d sweeps, %0d refused creates.",
             sent, sweeps_seen, creates_failed);
    if (fail_count == 0) begin
      $display("PASS generational_handle_allocator_core");
    end else begin
      $display("FAIL generational_handle_allocator_core");
    end
    $finish;
  end

endmodule
